// ----- rtl/core/lruq_pkg.sv -----
`default_nettype none
package lruq_pkg;

  // item kinds
  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // query offsets carried in the value field
  localparam logic signed [31:0] OFS_OLDER = -32'sd1;
  localparam logic signed [31:0] OFS_NEWER = 32'sd1;

  // register map (word index)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_NBR,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic select;
    logic nbr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/lruq_if.sv -----
`default_nettype none
interface lruq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [63:0]        key;
  logic signed [31:0] value;

  modport source(output valid, output kind, output key, output value, input ready);
  modport sink(input valid, input kind, input key, input value, output ready);
endinterface

interface lruq_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] data;

  modport source(output valid, output ok, output data, input ready);
  modport sink(input valid, input ok, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lru_cache_with_neighbor_query_unit.sv -----
`default_nettype none
// An access steps through the match, select and commit states after its input
// beat is taken; a query adds the neighbor state before commit. A clear goes
// from match straight to commit and gives no result. A new beat is taken only
// in idle, and commit waits while an untaken result beat is still held.
// Reset (rst_n low, synchronous): store empty, capacity register back to 16,
// output beat dropped. No clearing pass is needed.
module lru_cache_with_neighbor_query_unit #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lruq_in_if.sink          in_if,
  lruq_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [4:0] cap_r;
  logic       cap_we;
  lruq_pkg::cmd_t    cmd;
  lruq_pkg::status_t stat;
  logic       in_ready;

  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (paddr[2] == lruq_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == lruq_pkg::REG_CAPACITY) ? {27'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lruq_pkg::CAP_RESET;
    end else if (cap_we) begin
      cap_r <= pwdata[4:0];
    end
  end

  assign in_if.ready = in_ready;

  lruq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lruq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cap       (cap_r),
    .in_kind   (in_if.kind),
    .in_key    (in_if.key),
    .in_value  (in_if.value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_ok    (out_if.ok),
    .out_data  (out_if.data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/lruq_ctrl.sv -----
`default_nettype none
module lruq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lruq_pkg::status_t stat,
  output lruq_pkg::cmd_t        cmd
);

  lruq_pkg::state_t state_r, state_nxt;
  logic has_result;
  logic can_commit;

  assign has_result = (stat.kind == lruq_pkg::KIND_ACCESS) ||
                      (stat.kind == lruq_pkg::KIND_QUERY);
  assign can_commit = !has_result || !stat.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lruq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lruq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lruq_pkg::ST_MATCH;
      end
      lruq_pkg::ST_MATCH: begin
        state_nxt = has_result ? lruq_pkg::ST_SELECT : lruq_pkg::ST_COMMIT;
      end
      lruq_pkg::ST_SELECT: begin
        state_nxt = (stat.kind == lruq_pkg::KIND_QUERY) ? lruq_pkg::ST_NBR
                                                        : lruq_pkg::ST_COMMIT;
      end
      lruq_pkg::ST_NBR: begin
        state_nxt = lruq_pkg::ST_COMMIT;
      end
      lruq_pkg::ST_COMMIT: begin
        if (can_commit) state_nxt = lruq_pkg::ST_IDLE;
      end
      default: state_nxt = lruq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lruq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lruq_pkg::ST_MATCH:  cmd.match  = 1'b1;
      lruq_pkg::ST_SELECT: cmd.select = 1'b1;
      lruq_pkg::ST_NBR:    cmd.nbr    = 1'b1;
      lruq_pkg::ST_COMMIT: cmd.commit = can_commit;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/lruq_dp.sv -----
`default_nettype none
module lruq_dp #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lruq_pkg::cmd_t     cmd,
  output lruq_pkg::status_t       stat,
  input  wire logic [4:0]         cap,
  input  wire logic [1:0]         in_kind,
  input  wire logic [63:0]        in_key,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_ok,
  output logic signed [31:0]      out_data
);

  localparam int RW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCCW = $clog2(CAPACITY + 1);
  localparam int CW   = (OCCW > 5) ? OCCW : 5;

  // entry cells
  logic [CAPACITY-1:0] ent_valid_r, ent_valid_nxt;
  logic [KEY_BITS-1:0] ent_key_r  [CAPACITY];
  logic [KEY_BITS-1:0] ent_key_nxt[CAPACITY];
  logic [31:0]         ent_data_r  [CAPACITY];
  logic [31:0]         ent_data_nxt[CAPACITY];
  logic [RW-1:0]       ent_rank_r  [CAPACITY];
  logic [RW-1:0]       ent_rank_nxt[CAPACITY];
  logic [OCCW-1:0]     occ_r, occ_nxt;

  // current item
  logic [1:0]          item_kind_r;
  logic [KEY_BITS-1:0] item_key_r;
  logic signed [31:0]  item_val_r;

  // lookup results
  logic [CAPACITY-1:0] match_vec_r;
  logic [CAPACITY-1:0] nbr_vec_r;
  logic                hit_r;
  logic [RW-1:0]       hit_idx_r;
  logic [RW-1:0]       hit_rank_r;
  logic [31:0]         hit_data_r;
  logic                evict_r;
  logic                free_ok_r;
  logic [RW-1:0]       free_idx_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic signed [31:0]  out_data_r, out_data_nxt;

  // select-stage logic
  logic                hit_c;
  logic [RW-1:0]       hit_idx_c;
  logic [CW-1:0]       occ_c, cap_c, eff_c;
  logic                evict_c;
  logic                free_ok_c;
  logic [RW-1:0]       free_idx_c;
  logic [RW-1:0]       tgt_rank;

  // commit-stage logic
  logic                nbr_ok;
  logic [RW-1:0]       nbr_idx;
  logic [OCCW-1:0]     occ_e;
  logic                q_ok;
  logic [31:0]         q_data;
  logic                has_result;

  assign has_result = (item_kind_r == lruq_pkg::KIND_ACCESS) ||
                      (item_kind_r == lruq_pkg::KIND_QUERY);

  assign stat.kind     = item_kind_r;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_data  = out_data_r;

  always_comb begin
    hit_c     = |match_vec_r;
    hit_idx_c = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec_r[i]) hit_idx_c = RW'(i);
    end
  end

  // a miss evicts when the count would pass the effective capacity
  always_comb begin
    occ_c = CW'(occ_r);
    cap_c = CW'(cap);
    if (cap_c == '0) begin
      eff_c = CW'(1);
    end else if (cap_c > CW'(CAPACITY)) begin
      eff_c = CW'(CAPACITY);
    end else begin
      eff_c = cap_c;
    end
    evict_c = !hit_c && (occ_c >= eff_c);
  end

  always_comb begin
    free_ok_c  = 1'b0;
    free_idx_c = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!ent_valid_r[i] || (evict_c && ent_rank_r[i] == '0)) begin
        free_ok_c  = 1'b1;
        free_idx_c = RW'(i);
      end
    end
  end

  assign tgt_rank = (item_val_r == lruq_pkg::OFS_OLDER) ? hit_rank_r - RW'(1)
                                                        : hit_rank_r + RW'(1);

  always_comb begin
    nbr_ok  = |nbr_vec_r;
    nbr_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (nbr_vec_r[i]) nbr_idx = RW'(i);
    end
  end

  always_comb begin
    q_ok   = 1'b0;
    q_data = '0;
    if (hit_r) begin
      if (item_val_r == lruq_pkg::OFS_OLDER) begin
        if (hit_rank_r != '0 && nbr_ok) begin
          q_ok   = 1'b1;
          q_data = ent_data_r[nbr_idx];
        end
      end else if (item_val_r == lruq_pkg::OFS_NEWER) begin
        if ((OCCW'(hit_rank_r) + OCCW'(1) < occ_r) && nbr_ok) begin
          q_ok   = 1'b1;
          q_data = ent_data_r[nbr_idx];
        end
      end else begin
        q_ok   = 1'b1;
        q_data = hit_data_r;
      end
    end
  end

  assign occ_e = (evict_r && occ_r != '0) ? occ_r - OCCW'(1) : occ_r;

  always_comb begin
    ent_valid_nxt = ent_valid_r;
    ent_key_nxt   = ent_key_r;
    ent_data_nxt  = ent_data_r;
    ent_rank_nxt  = ent_rank_r;
    occ_nxt       = occ_r;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    if (cmd.commit) begin
      case (item_kind_r)
        lruq_pkg::KIND_CLEAR: begin
          ent_valid_nxt = '0;
          occ_nxt       = '0;
        end
        lruq_pkg::KIND_ACCESS: begin
          out_ok_nxt = 1'b1;
          if (hit_r) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (ent_valid_r[i] && ent_rank_r[i] > hit_rank_r) begin
                ent_rank_nxt[i] = ent_rank_r[i] - RW'(1);
              end
            end
            ent_rank_nxt[hit_idx_r] = RW'(occ_r - OCCW'(1));
            out_data_nxt = hit_data_r;
          end else begin
            if (evict_r) begin
              for (int i = 0; i < CAPACITY; i++) begin
                if (ent_valid_r[i]) begin
                  if (ent_rank_r[i] == '0) ent_valid_nxt[i] = 1'b0;
                  else ent_rank_nxt[i] = ent_rank_r[i] - RW'(1);
                end
              end
            end
            occ_nxt = occ_e;
            if (free_ok_r) begin
              ent_valid_nxt[free_idx_r] = 1'b1;
              ent_key_nxt[free_idx_r]   = item_key_r;
              ent_data_nxt[free_idx_r]  = item_val_r;
              ent_rank_nxt[free_idx_r]  = RW'(occ_e);
              occ_nxt                   = occ_e + OCCW'(1);
            end
            out_data_nxt = item_val_r;
          end
        end
        lruq_pkg::KIND_QUERY: begin
          out_ok_nxt   = q_ok;
          out_data_nxt = q_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd.commit && has_result) out_valid_nxt = 1'b1;
    else if (out_ready)           out_valid_nxt = 1'b0;
    else                          out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_key_r  <= ent_key_nxt;
    ent_data_r <= ent_data_nxt;
    ent_rank_r <= ent_rank_nxt;
    out_ok_r   <= out_ok_nxt;
    out_data_r <= out_data_nxt;
    if (cmd.load) begin
      item_kind_r <= in_kind;
      item_key_r  <= in_key[KEY_BITS-1:0];
      item_val_r  <= in_value;
    end
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_vec_r[i] <= ent_valid_r[i] && (ent_key_r[i] == item_key_r);
      end
    end
    if (cmd.select) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      hit_rank_r <= ent_rank_r[hit_idx_c];
      hit_data_r <= ent_data_r[hit_idx_c];
      evict_r    <= evict_c;
      free_ok_r  <= free_ok_c;
      free_idx_r <= free_idx_c;
    end
    if (cmd.nbr) begin
      for (int i = 0; i < CAPACITY; i++) begin
        nbr_vec_r[i] <= ent_valid_r[i] && (ent_rank_r[i] == tgt_rank);
      end
    end
  end

  // valid keys are unique, so at most one cell matches
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.select |-> $onehot0(match_vec_r))
    else $error("more than one cell matched the key");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ent_valid_r) == int'(occ_r))
    else $error("occupancy disagrees with valid cells");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= CAPACITY)
    else $error("occupancy above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && has_result) |-> !(out_valid_r && !out_ready))
    else $error("result beat overwritten before taken");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;

  localparam int SLOTS = 16;
  localparam int KEY_POOL = 24;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_STALL = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] CAP_ADDR = {lruq_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        key;
    logic signed [31:0] value;
  } lru_req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] data;
  } lru_reply_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lruq_in_if in_ch();
  lruq_out_if out_ch();

  lru_cache_with_neighbor_query_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the store
  bit          slot_valid [SLOTS];
  logic [63:0] slot_key [SLOTS];
  logic [31:0] slot_data [SLOTS];
  int          slot_rank [SLOTS];
  int          slot_count = 0;
  logic [4:0]  cfg_capacity = lruq_pkg::CAP_RESET;

  lru_req_t   pending_requests[$];
  lru_reply_t expected_replies[$];
  logic [63:0] key_pool [KEY_POOL];
  logic [4:0] phase_caps [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd16, 5'd4, 5'd17, 5'd2, 5'd8};

  int error_count = 0;
  logic in_took = 1'b0;
  lru_req_t head_req;
  lru_reply_t want;
  int burst_left = 8;
  int gap_left = 0;
  int long_stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int rx_span = 20;
  int rx_tick = 0;

  function automatic int slot_of_rank(input int rank);
    int found;
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_rank[i] == rank && found < 0) found = i;
    return found;
  endfunction

  function automatic void update_lru_store(input lru_req_t r);
    int hit;
    int pick;
    int limit;
    int base;
    lru_reply_t rep;
    hit = -1;
    pick = -1;
    if (r.kind == lruq_pkg::KIND_CLEAR) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      slot_count = 0;
      return;
    end
    if (r.kind == KIND_UNUSED) return;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_key[i] == r.key && hit < 0) hit = i;
    if (r.kind == lruq_pkg::KIND_ACCESS) begin
      rep.ok = 1'b1;
      if (hit >= 0) begin
        base = slot_rank[hit];
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && slot_rank[i] > base) slot_rank[i]--;
        slot_rank[hit] = slot_count - 1;
        rep.data = slot_data[hit];
      end else begin
        limit = (cfg_capacity == 0) ? 1 : (cfg_capacity > SLOTS) ? SLOTS : int'(cfg_capacity);
        // a lowered capacity only trims one oldest entry per miss
        if (slot_count + 1 > limit || slot_count >= SLOTS) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
              if (slot_rank[i] == 0) slot_valid[i] = 1'b0;
              else slot_rank[i]--;
            end
          end
          if (slot_count > 0) slot_count--;
        end
        for (int i = 0; i < SLOTS; i++)
          if (!slot_valid[i] && pick < 0) pick = i;
        if (pick >= 0) begin
          slot_valid[pick] = 1'b1;
          slot_key[pick] = r.key;
          slot_data[pick] = r.value;
          slot_rank[pick] = slot_count;
          slot_count++;
        end
        rep.data = r.value;
      end
      expected_replies.push_back(rep);
      return;
    end
    rep.ok = 1'b0;
    rep.data = '0;
    if (hit >= 0) begin
      pick = hit;
      if (r.value == lruq_pkg::OFS_OLDER)
        pick = (slot_rank[hit] == 0) ? -1 : slot_of_rank(slot_rank[hit] - 1);
      else if (r.value == lruq_pkg::OFS_NEWER)
        pick = (slot_rank[hit] + 1 >= slot_count) ? -1 : slot_of_rank(slot_rank[hit] + 1);
      if (pick >= 0) begin
        rep.ok = 1'b1;
        rep.data = slot_data[pick];
      end
    end
    expected_replies.push_back(rep);
  endfunction

  function automatic lru_req_t make_request();
    lru_req_t r;
    int roll;
    int span;
    span = (cfg_capacity == 0) ? 5 : (cfg_capacity > SLOTS) ? SLOTS + 4 : cfg_capacity + 4;
    roll = $urandom_range(0, 99);
    r.kind = (roll < 56) ? lruq_pkg::KIND_ACCESS :
             (roll < 96) ? lruq_pkg::KIND_QUERY :
             (roll < 98) ? lruq_pkg::KIND_CLEAR : KIND_UNUSED;
    r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
            key_pool[$urandom_range(0, span - 1)];
    roll = $urandom_range(0, 99);
    if (r.kind == lruq_pkg::KIND_QUERY && roll < 70)
      r.value = (roll < 35) ? lruq_pkg::OFS_OLDER : lruq_pkg::OFS_NEWER;
    else if (r.kind == lruq_pkg::KIND_QUERY && roll < 82) r.value = '0;
    else r.value = $urandom;
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [63:0] key,
                            input logic signed [31:0] value);
    pending_requests.push_back({kind, key, value});
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= {27'd0, cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_capacity = cap;
  endtask

  // clears can still be in flight after the last reply, hence the settle time
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    if (!in_ch.valid || in_took) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        head_req = pending_requests.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= head_req.kind;
        in_ch.key <= head_req.key;
        in_ch.value <= head_req.value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, plus one long stall on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (stall_seen != long_stall_req) begin
      stall_seen = long_stall_req;
      stall_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(10, 60);
      end else begin
        rx_span--;
      end
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_THIRD:  out_ch.ready <= (rx_tick % 3 == 0);
        default:   out_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // result check first, then prediction for the beat taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("result beat with nothing expected: ok=%0b data=%0d", out_ch.ok, out_ch.data);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.ok !== want.ok) begin
          $error("ok mismatch: expected %0b, actual %0b", want.ok, out_ch.ok);
          error_count++;
        end
        if (out_ch.data !== want.data) begin
          $error("data mismatch: expected %0d, actual %0d", want.data, out_ch.data);
          error_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      update_lru_store({in_ch.kind, in_ch.key, in_ch.value});
    in_took <= rst_n && in_ch.valid && in_ch.ready;
  end

  initial begin
    int n;
    lru_req_t r;
    in_ch.valid = 1'b0;
    in_ch.kind = lruq_pkg::KIND_ACCESS;
    in_ch.key = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'd1;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, field extremes, hits, neighbors at both ends, clear
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], 32'sd0);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[0], 32'sh7fff_ffff);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[1], 32'sh8000_0000);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[2], 32'sd0);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[3], -32'sd1);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[0], 32'sd5);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[1], lruq_pkg::OFS_OLDER);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[1], lruq_pkg::OFS_NEWER);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], lruq_pkg::OFS_NEWER);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], lruq_pkg::OFS_OLDER);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[2], 32'sh1234_5678);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[4], 32'sd0);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[4], lruq_pkg::OFS_OLDER);
    queue_item(KIND_UNUSED, key_pool[0], 32'sd0);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[3], 32'sd9);
    queue_item(lruq_pkg::KIND_CLEAR, key_pool[0], 32'sd0);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], 32'sd0);
    queue_item(lruq_pkg::KIND_ACCESS, key_pool[0], 32'sh0000_55aa);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], lruq_pkg::OFS_NEWER);
    queue_item(lruq_pkg::KIND_QUERY, key_pool[0], lruq_pkg::OFS_OLDER);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_capacity(phase_caps[p]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = make_request();
        pending_requests.push_back(r);
        if (r.kind != KIND_UNUSED) n++;
      end
      // hold the receiver off so the unit backs up into its input
      if (p == 3) long_stall_req++;
    end
    drain_and_settle();

    if (error_count == 0) begin
      $display("lru_cache_with_neighbor_query_unit test passed");
    end else begin
      $display("lru_cache_with_neighbor_query_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("lru_cache_with_neighbor_query_unit test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/lruq_pkg.sv
rtl/core/lruq_if.sv
rtl/core/lruq_ctrl.sv
rtl/core/lruq_dp.sv
rtl/core/lru_cache_with_neighbor_query_unit.sv
bench/testbench.sv
